/* rtl/core/gradient_3x3_clamped_filter_macros.svh */
// Assertion macros shared by the vertical gradient filter RTL.
`ifndef GRADIENT_3X3_CLAMPED_FILTER_MACROS_SVH
`define GRADIENT_3X3_CLAMPED_FILTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define G3_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gradient filter: same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define G3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gradient filter: next-cycle check failed");
`else
`define G3_ASSERT_IMPL(label, ante, cons)
`define G3_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/grad3_pkg.sv */
// Package with the types and constants of the vertical gradient filter.
`timescale 1ns / 1ps
package grad3_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;
  localparam int HEIGHT_W     = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int MIN_DIM      = 3;
  localparam int MAX_HEIGHT   = 4096;
  localparam int DIM_RESET    = 1024;
  localparam int LINE_WORD_W  = 2 * PIX_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_t;

  // Input pixel transaction.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [PIX_W-1:0]     edge_value;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 last_of_frame;
  } out_item_t;

  // Configuration write transaction.
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // Position status of one accepted pixel, handed from the counters to the pipeline.
  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } pos_info_t;

endpackage

/* rtl/core/grad3_ifs.sv */
// Valid/ready channel interfaces for pixels, results and configuration writes.
`timescale 1ns / 1ps
interface grad3_in_if;
  logic                valid;
  logic                ready;
  grad3_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grad3_out_if;
  logic                 valid;
  logic                 ready;
  grad3_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grad3_cfg_if;
  logic                 valid;
  logic                 ready;
  grad3_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/grad3_line_mem.sv */
// Line buffer memory: one word per column holds the two rows above.
`timescale 1ns / 1ps
module grad3_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [$clog2(DEPTH)-1:0]               rd_addr,
  output logic [grad3_pkg::LINE_WORD_W-1:0]      rd_data,
  input  logic                                   wr_en,
  input  logic [$clog2(DEPTH)-1:0]               wr_addr,
  input  logic [grad3_pkg::LINE_WORD_W-1:0]      wr_data
);

  logic [grad3_pkg::LINE_WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/grad3_pos_ctr.sv */
// Frame geometry registers and the row/column position counters.
`timescale 1ns / 1ps
module grad3_pos_ctr #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  grad3_pkg::cfg_item_t          cfg_item,
  input  logic                          advance,
  input  logic                          frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0]  addr,
  output grad3_pkg::pos_info_t          info
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = grad3_pkg::HEIGHT_W;
  localparam int RW      = grad3_pkg::ROW_W;
  localparam int W_RESET = (grad3_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : grad3_pkg::DIM_RESET;

  logic [WW-1:0] eff_w_r;
  logic [HW-1:0] eff_h_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  logic [grad3_pkg::WIDTH_REG_W-1:0] wval;
  logic [HW-1:0]                     hval;
  logic [WW-1:0]                     w_clamped;
  logic [HW-1:0]                     h_clamped;
  logic                              upd_w;
  logic                              upd_h;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] col_m1;
  logic          last_col;
  logic          last_row;

  // Register decode; unknown indexes are ignored.
  always_comb begin
    upd_w = 1'b0;
    upd_h = 1'b0;
    if (cfg_we) begin
      unique case (cfg_item.reg_index)
        grad3_pkg::REG_IMAGE_WIDTH:  upd_w = 1'b1;
        grad3_pkg::REG_IMAGE_HEIGHT: upd_h = 1'b1;
        default: ;
      endcase
    end
  end

  // Clamp the written geometry to the supported range.
  assign wval = cfg_item.wdata[grad3_pkg::WIDTH_REG_W-1:0];
  assign hval = cfg_item.wdata[HW-1:0];

  always_comb begin
    if (32'(wval) > MAX_WIDTH) begin
      w_clamped = WW'(MAX_WIDTH);
    end else if (32'(wval) < grad3_pkg::MIN_DIM) begin
      w_clamped = WW'(grad3_pkg::MIN_DIM);
    end else begin
      w_clamped = WW'(wval);
    end
  end

  always_comb begin
    if (32'(hval) > grad3_pkg::MAX_HEIGHT) begin
      h_clamped = HW'(grad3_pkg::MAX_HEIGHT);
    end else if (32'(hval) < grad3_pkg::MIN_DIM) begin
      h_clamped = HW'(grad3_pkg::MIN_DIM);
    end else begin
      h_clamped = hval;
    end
  end

  // Position of the pixel being accepted; a frame start restarts at the origin.
  assign cur_col  = frame_start ? '0 : col_r;
  assign cur_row  = frame_start ? '0 : row_r;
  assign last_col = (WW'(cur_col) + WW'(1)) >= eff_w_r;
  assign last_row = (HW'(cur_row) + HW'(1)) >= eff_h_r;
  assign col_m1   = cur_col - CW'(1);

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : cur_row + RW'(1);
    end else begin
      col_nxt = cur_col + CW'(1);
      row_nxt = cur_row;
    end
  end

  assign addr      = cur_col;
  assign info.emit = (cur_row >= RW'(2)) && (CW'(cur_col) >= CW'(2));
  assign info.last = last_row && last_col;
  assign info.row  = cur_row - RW'(1);
  assign info.col  = grad3_pkg::COL_OUT_W'(col_m1);

  // Geometry and counter registers; a register write restarts the counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(W_RESET);
      eff_h_r <= HW'(grad3_pkg::DIM_RESET);
      col_r   <= '0;
      row_r   <= '0;
    end else if (upd_w || upd_h) begin
      if (upd_w) begin
        eff_w_r <= w_clamped;
      end
      if (upd_h) begin
        eff_h_r <= h_clamped;
      end
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/core/grad3_kernel.sv */
// Window shift registers and the clamped vertical gradient.
`timescale 1ns / 1ps
module grad3_kernel (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  logic [grad3_pkg::PIX_W-1:0]  pix,
  input  logic [grad3_pkg::PIX_W-1:0]  top,
  output logic [grad3_pkg::PIX_W-1:0]  edge_value
);

  localparam int PW = grad3_pkg::PIX_W;
  localparam int SW = PW + 3;

  logic [PW-1:0] top0_r;
  logic [PW-1:0] top1_r;
  logic [PW-1:0] bot0_r;
  logic [PW-1:0] bot1_r;
  logic [SW-1:0] sum;

  // Bottom row minus top row; the true value always fits in SW bits.
  assign sum = SW'(bot0_r) + SW'(bot1_r) + SW'(pix)
             - SW'(top0_r) - SW'(top1_r) - SW'(top);

  // Clamp to the pixel range.
  always_comb begin
    if (sum[SW-1]) begin
      edge_value = '0;
    end else if (sum[SW-2:PW] != '0) begin
      edge_value = '1;
    end else begin
      edge_value = sum[PW-1:0];
    end
  end

  // The window slides by one column per pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top0_r <= '0;
      top1_r <= '0;
      bot0_r <= '0;
      bot1_r <= '0;
    end else if (shift) begin
      top0_r <= top1_r;
      top1_r <= top;
      bot0_r <= bot1_r;
      bot1_r <= pix;
    end
  end

endmodule

/* rtl/core/gradient_3x3_clamped_filter.sv */
// Top level of the 3x3 vertical gradient filter with clamped output.
//
// Usage: pixels enter on in_ch in raster order, one per transaction; frame_start
// marks the pixel at row 0, column 0. A result transaction on out_ch carries the
// clamped gradient of an interior pixel with its row, column and a last-of-frame
// flag. Border pixels yield no result. cfg_ch writes image_width (index 0) and
// image_height (index 1); it is always ready, and any such write restarts the
// position counters. The user must change configuration only while the block
// is idle; the block does not enforce it. The pixel completing a window passes
// the memory stage and its result the result register. One pixel per cycle while
// out_ch does not stall; the line memory is read at accept, written back as the
// pixel leaves the memory stage, and a read of that column then is forwarded.
// Reset clears the counters, the window and the pipeline valids; geometry goes
// to 1024 x 1024 (width limited to MAX_WIDTH). The line memory is not cleared.
// When out_ch stalls, the result register holds, the pixel in the memory
// stage waits behind it and in_ch drops ready in the same cycle.
`timescale 1ns / 1ps
`include "gradient_3x3_clamped_filter_macros.svh"
module gradient_3x3_clamped_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  grad3_in_if.sink     in_ch,
  grad3_out_if.source  out_ch,
  grad3_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = grad3_pkg::PIX_W;
  localparam int LW = grad3_pkg::LINE_WORD_W;

  logic                 in_fire;
  logic                 s1_fire;
  logic [CW-1:0]        addr;
  grad3_pkg::pos_info_t info;

  logic                 s1_valid_r;
  logic [PW-1:0]        s1_pix_r;
  logic [CW-1:0]        s1_addr_r;
  grad3_pkg::pos_info_t s1_info_r;
  logic                 fwd_r;
  logic [LW-1:0]        fwd_data_r;
  logic                 fwd_nxt;

  logic [LW-1:0]        rd_data;
  logic [LW-1:0]        line_word;
  logic [PW-1:0]        s1_top;
  logic [PW-1:0]        s1_mid;
  logic [LW-1:0]        wb_word;
  logic [PW-1:0]        edge_value;

  logic                 out_valid_r;
  grad3_pkg::out_item_t out_item_r;

  // Handshakes; the memory stage moves on when the result register can take it.
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign cfg_ch.ready = 1'b1;

  grad3_pos_ctr #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos_ctr (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_ch.valid),
    .cfg_item    (cfg_ch.data),
    .advance     (in_fire),
    .frame_start (in_ch.data.frame_start),
    .addr        (addr),
    .info        (info)
  );

  // Write-back word: the row above moves up, the new pixel becomes the row above.
  assign line_word = fwd_r ? fwd_data_r : rd_data;
  assign s1_top    = line_word[LW-1:PW];
  assign s1_mid    = line_word[PW-1:0];
  assign wb_word   = {s1_mid, s1_pix_r};

  grad3_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr_r),
    .wr_data (wb_word)
  );

  // A read of the column being written back in the same cycle sees stale data.
  assign fwd_nxt = in_fire && s1_valid_r && (s1_addr_r == addr);

  // Memory stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= fwd_nxt;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_ch.data.pixel;
      s1_addr_r  <= addr;
      s1_info_r  <= info;
      fwd_data_r <= wb_word;
    end
  end

  grad3_kernel u_kernel (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift      (s1_fire),
    .pix        (s1_pix_r),
    .top        (s1_top),
    .edge_value (edge_value)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= s1_info_r.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_info_r.emit) begin
      out_item_r.edge_value    <= edge_value;
      out_item_r.out_row       <= s1_info_r.row;
      out_item_r.out_col       <= s1_info_r.col;
      out_item_r.last_of_frame <= s1_info_r.last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // An accepted pixel always lands in the memory stage.
  `G3_ASSERT_NEXT(a_accept_fills_stage, in_fire, s1_valid_r)
  // A stalled memory stage keeps its pixel and column.
  `G3_ASSERT_NEXT(a_stage_holds, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_addr_r))
  // Forwarded data only belongs to a live pixel.
  `G3_ASSERT_IMPL(a_fwd_needs_valid, fwd_r, s1_valid_r)
  // An interior pixel leaving the memory stage shows up as a result.
  `G3_ASSERT_NEXT(a_emit_reaches_out, s1_fire && s1_info_r.emit, out_valid_r)

endmodule

/* test/tb_gradient_3x3_clamped_filter.sv */
// Self-checking testbench for the clamped 3x3 vertical gradient filter.
`timescale 1ns / 1ps
module tb_gradient_3x3_clamped_filter;

  localparam int     MAX_WIDTH      = 1024;
  localparam int     PW             = grad3_pkg::PIX_W;
  localparam int     IDX_W          = grad3_pkg::CFG_IDX_W;
  localparam int     DATA_W         = grad3_pkg::CFG_DATA_W;
  localparam int     WREG_W         = grad3_pkg::WIDTH_REG_W;
  localparam int     HREG_W         = grad3_pkg::HEIGHT_W;
  localparam int     ROW_OUT_W      = grad3_pkg::ROW_W;
  localparam int     COL_OUT_W      = grad3_pkg::COL_OUT_W;
  localparam int     W_JUNK_W       = DATA_W - WREG_W;
  localparam int     H_JUNK_W       = DATA_W - HREG_W;
  localparam int     COL_IDX_W      = $clog2(MAX_WIDTH);
  localparam int     CLK_HALF       = 5;
  localparam int     RESET_CYCLES   = 6;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     DRAIN_LIMIT    = 5000;
  localparam int     MAX_BURST      = 18;
  localparam int     LONG_HOLD      = 200;
  localparam int     RANDOM_PIXELS  = 700;
  localparam longint CYCLE_LIMIT    = 3_000_000;
  localparam logic [IDX_W-1:0] UNUSED_REG_IDX = 8'hA5;
  localparam int     FIRST_FREE_IDX = int'(grad3_pkg::REG_IMAGE_HEIGHT) + 1;
  localparam int     LAST_IDX       = (1 << IDX_W) - 1;

  // Pixel content styles for generated frames.
  typedef enum int {PAT_RANDOM, PAT_BINARY, PAT_RAMP} pattern_t;

  logic clk;
  logic rst_n;

  grad3_in_if  in_ch ();
  grad3_out_if out_ch ();
  grad3_cfg_if cfg_ch ();

  gradient_3x3_clamped_filter #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the filter state: two delayed rows, window taps, position and geometry.
  logic [PW-1:0]           line_prev2 [MAX_WIDTH];
  logic [PW-1:0]           line_prev1 [MAX_WIDTH];
  logic [PW-1:0]           top_taps [2];
  logic [PW-1:0]           bottom_taps [2];
  int unsigned             pos_col;
  int unsigned             pos_row;
  logic [WREG_W-1:0]       width_reg;
  logic [HREG_W-1:0]       height_reg;
  grad3_pkg::out_item_t    expected_edges [$];

  int     error_count;
  int     pixels_sent;
  int     results_checked;
  int     frames_closed;
  int     reg_writes;
  longint cycle_count;

  // Idling knobs shared by the sender and the result receiver.
  int gap_pct;
  int stall_pct;
  int hold_request;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void reset_predictor();
    foreach (line_prev2[i]) begin
      line_prev2[i] = '0;
      line_prev1[i] = '0;
    end
    top_taps    = '{default: '0};
    bottom_taps = '{default: '0};
    pos_col     = 0;
    pos_row     = 0;
    width_reg   = WREG_W'(grad3_pkg::DIM_RESET);
    height_reg  = HREG_W'(grad3_pkg::DIM_RESET);
  endfunction

  // A geometry write restarts the position; unknown indexes change nothing.
  function automatic void predict_config(input grad3_pkg::cfg_item_t wr);
    unique case (wr.reg_index)
      grad3_pkg::REG_IMAGE_WIDTH: begin
        width_reg = wr.wdata[WREG_W-1:0];
        pos_col   = 0;
        pos_row   = 0;
      end
      grad3_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = wr.wdata[HREG_W-1:0];
        pos_col    = 0;
        pos_row    = 0;
      end
      default: ;
    endcase
  endfunction

  // Advance the mirrored state by one pixel and queue the gradient it completes.
  function automatic void predict_gradient(input grad3_pkg::in_item_t px);
    int unsigned          w_eff;
    int unsigned          h_eff;
    int unsigned          c;
    int unsigned          r;
    int                   sum;
    logic [COL_IDX_W-1:0] idx;
    logic [PW-1:0]        top;
    logic [PW-1:0]        mid;
    grad3_pkg::out_item_t res;
    w_eff = 32'(width_reg);
    if (w_eff < grad3_pkg::MIN_DIM) w_eff = grad3_pkg::MIN_DIM;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = 32'(height_reg);
    if (h_eff < grad3_pkg::MIN_DIM) h_eff = grad3_pkg::MIN_DIM;
    if (h_eff > grad3_pkg::MAX_HEIGHT) h_eff = grad3_pkg::MAX_HEIGHT;
    if (px.frame_start) begin
      pos_col = 0;
      pos_row = 0;
    end
    c = (pos_col >= w_eff) ? w_eff - 1 : pos_col;
    r = (pos_row >= h_eff) ? h_eff - 1 : pos_row;
    idx = COL_IDX_W'(c);

    top = line_prev2[idx];
    mid = line_prev1[idx];
    line_prev2[idx] = mid;
    line_prev1[idx] = px.pixel;

    // Interior pixel one row up and one column left is now complete.
    if (r >= 2 && c >= 2) begin
      sum = int'(bottom_taps[0]) + int'(bottom_taps[1]) + int'(px.pixel)
          - int'(top_taps[0]) - int'(top_taps[1]) - int'(top);
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      res.edge_value    = PW'(sum);
      res.out_row       = ROW_OUT_W'(r - 1);
      res.out_col       = COL_OUT_W'(c - 1);
      res.last_of_frame = (r == h_eff - 1) && (c == w_eff - 1);
      expected_edges.push_back(res);
    end

    top_taps[0]    = top_taps[1];
    top_taps[1]    = top;
    bottom_taps[0] = bottom_taps[1];
    bottom_taps[1] = px.pixel;

    if (c + 1 >= w_eff) begin
      pos_col = 0;
      pos_row = (r + 1 >= h_eff) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      pos_row = r;
    end
  endfunction

  // Result receiver: random stall bursts plus an optional long counted hold.
  initial begin
    int   stall_left;
    int   hold_left;
    logic ready_next;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, MAX_BURST) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ch.ready <= ready_next;
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  initial begin
    grad3_pkg::out_item_t got;
    grad3_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                    got.out_row, got.out_col, got.edge_value));
        end else begin
          want = expected_edges.pop_front();
          results_checked++;
          if (want.last_of_frame) frames_closed++;
          if (got.edge_value !== want.edge_value)
            report_mismatch($sformatf("edge_value %0d, expected %0d at row %0d col %0d",
                                      got.edge_value, want.edge_value,
                                      want.out_row, want.out_col));
          if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, expected %0d",
                                      got.out_row, want.out_row));
          if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, expected %0d",
                                      got.out_col, want.out_col));
          if (got.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame %0b, expected %0b at row %0d col %0d",
                                      got.last_of_frame, want.last_of_frame,
                                      want.out_row, want.out_col));
        end
      end
    end
  end

  // Offer one pixel transaction, possibly after an idle burst, and predict it once taken.
  task automatic send_pixel(input logic [PW-1:0] pix, input logic fs);
    grad3_pkg::in_item_t item;
    int                  gap;
    item.pixel       = pix;
    item.frame_start = fs;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, MAX_BURST);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    predict_gradient(item);
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until every result is in and the pipeline is empty.
  task automatic wait_until_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_edges.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_edges.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_edges.size()));
      expected_edges.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    grad3_pkg::cfg_item_t wr;
    wr.reg_index = idx;
    wr.wdata     = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= wr;
    do @(posedge clk); while (!cfg_ch.ready);
    predict_config(wr);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [DATA_W-1:0] w_val,
                              input logic [DATA_W-1:0] h_val);
    wait_until_idle();
    if ($urandom_range(0, 1)) begin
      write_register(grad3_pkg::REG_IMAGE_WIDTH, w_val);
      write_register(grad3_pkg::REG_IMAGE_HEIGHT, h_val);
    end else begin
      write_register(grad3_pkg::REG_IMAGE_HEIGHT, h_val);
      write_register(grad3_pkg::REG_IMAGE_WIDTH, w_val);
    end
  endtask

  // Send one frame of w x h pixels in raster order, or only its first cut pixels.
  task automatic send_frame(input int unsigned w, input int unsigned h, input logic with_start,
                            input pattern_t pat, input int unsigned cut);
    int unsigned   total;
    int unsigned   r;
    int unsigned   c;
    logic [PW-1:0] base;
    logic [PW-1:0] pix;
    total = w * h;
    if (cut != 0 && cut < total) total = cut;
    base = PW'($urandom_range(0, 255));
    for (int unsigned i = 0; i < total; i++) begin
      r = i / w;
      c = i % w;
      case (pat)
        PAT_BINARY: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PAT_RAMP:   pix = base + PW'(r * 40 + c * 3);
        default:    pix = PW'($urandom_range(0, 255));
      endcase
      send_pixel(pix, with_start && i == 0);
    end
  endtask

  // Smallest useful frame with both clamp limits hit; upper data bits must be dropped.
  task automatic test_clamp_extremes();
    logic [PW-1:0] frame_px [12];
    frame_px = '{8'd0,   8'd0,   8'd255, 8'd255,
                 8'd128, 8'd64,  8'd32,  8'd16,
                 8'd255, 8'd255, 8'd0,   8'd0};
    set_geometry(16'hF804, 16'hE003);
    for (int i = 0; i < 12; i++) send_pixel(frame_px[i], i == 0);
  endtask

  // The counters wrapped after the last frame; restart it partway through row one.
  task automatic test_frame_restart();
    repeat (6) send_pixel(PW'($urandom_range(0, 255)), 1'b0);
    send_frame(4, 3, 1'b1, PAT_BINARY, 0);
  endtask

  // Widths and heights below the minimum, and a write to an unused index mid-frame.
  task automatic test_unknown_register();
    set_geometry(16'd0, 16'd2);
    for (int i = 0; i < 4; i++) send_pixel(PW'($urandom_range(0, 255)), i == 0);
    wait_until_idle();
    write_register(UNUSED_REG_IDX, 16'hFFFF);
    for (int i = 4; i < 9; i++) send_pixel(PW'($urandom_range(0, 255)), 1'b0);
  endtask

  // Largest geometries: clamped width, clamped 4096-row height, and a wide full frame.
  task automatic test_extreme_geometry();
    gap_pct   = 5;
    stall_pct = 5;
    set_geometry(16'hFFFF, 16'd3);
    send_frame(1024, 3, 1'b1, PAT_RANDOM, 48);
    set_geometry(16'd3, 16'hFFFF);
    send_frame(3, 4096, 1'b1, PAT_BINARY, 60);
    set_geometry(16'd40, 16'd3);
    send_frame(40, 3, 1'b1, PAT_RAMP, 0);
  endtask

  // Hold the result side for a long stretch while pixels keep coming.
  task automatic test_output_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    set_geometry(16'd8, 16'd6);
    hold_request = LONG_HOLD;
    send_frame(8, 6, 1'b1, PAT_RANDOM, 0);
    send_frame(8, 6, 1'b0, PAT_RAMP, 0);
  endtask

  // Random geometries and frames, with broken frames, stray pixels and unused writes.
  task automatic test_random_frames();
    int                pct_choices [4];
    int                start_count;
    int unsigned       w;
    int unsigned       h;
    int                kind;
    logic              need_start;
    logic [DATA_W-1:0] w_val;
    logic [DATA_W-1:0] h_val;
    pattern_t          pat;
    pct_choices = '{0, 5, 15, 30};
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      gap_pct   = pct_choices[$urandom_range(0, 3)];
      stall_pct = pct_choices[$urandom_range(0, 3)];
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(3, 16);
      h = $urandom_range(3, 10);
      w_val = DATA_W'(w);
      h_val = DATA_W'(h);
      if (w == 3 && $urandom_range(0, 1)) w_val = DATA_W'($urandom_range(0, 2));
      if (h == 3 && $urandom_range(0, 1)) h_val = DATA_W'($urandom_range(0, 2));
      // Bits above the register fields are junk and must be ignored.
      w_val[DATA_W-1:WREG_W] = W_JUNK_W'($urandom);
      h_val[DATA_W-1:HREG_W] = H_JUNK_W'($urandom);
      set_geometry(w_val, h_val);
      need_start = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        pat  = pattern_t'($urandom_range(0, 2));
        if (kind == 0) begin
          // Stray pixels with occasional frame starts.
          repeat ($urandom_range(1, w * h - 1))
            send_pixel(PW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          need_start = 1'b1;
        end else if (kind == 1) begin
          send_frame(w, h, 1'b1, pat, $urandom_range(1, w * h - 1));
          need_start = 1'b1;
        end else begin
          send_frame(w, h, need_start || $urandom_range(0, 1), pat, 0);
          need_start = 1'b0;
        end
        if ($urandom_range(0, 5) == 0) begin
          wait_until_idle();
          write_register(IDX_W'($urandom_range(FIRST_FREE_IDX, LAST_IDX)),
                         DATA_W'($urandom));
        end
      end
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back();
    int unsigned w;
    int unsigned h;
    gap_pct   = 0;
    stall_pct = 0;
    w = $urandom_range(3, 12);
    h = $urandom_range(3, 6);
    set_geometry(DATA_W'(w), DATA_W'(h));
    send_frame(w, h, 1'b1, PAT_RANDOM, 0);
    send_frame(w, h, 1'b0, PAT_BINARY, 0);
    send_frame(w, h, 1'b0, PAT_RAMP, 0);
  endtask

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data      = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    error_count     = 0;
    pixels_sent     = 0;
    results_checked = 0;
    frames_closed   = 0;
    reg_writes      = 0;
    gap_pct         = 10;
    stall_pct       = 10;
    hold_request    = 0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_clamp_extremes();
    test_frame_restart();
    test_unknown_register();
    test_output_backpressure();
    test_extreme_geometry();
    test_random_frames();
    test_back_to_back();
    wait_until_idle();

    $display("Sent %0d pixels, checked %0d gradients over %0d complete frames.",
             pixels_sent, results_checked, frames_closed);
    $display("Issued %0d register writes; widths to the 1024 limit, heights to 4096, %s",
             reg_writes, "idle bursts and a long output stall.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
